// File: rtl/tdl_pkg.sv
package tdl_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int SEGS_PER_ENTRY_DEF = 1;

	// working width of the shared multiplier product and rounding
	localparam int MW = 68;
	// divider numerator and remainder widths
	localparam int DIV_W = 56;
	localparam int REM_W = 31;
	// bits of the exp argument in q16
	localparam int EXP_BITS = 20;

	// dt * beta at which dt*beta*256/1000 reaches 2^20 and exp underflows
	localparam int X_LIMIT = 4096000;
	// ceil(2^40 / 1000): exact floor division by 1000 below 2^30
	localparam logic [30:0] X_RECIP = 31'd1099511628;
	localparam int X_SHIFT = 40;

	localparam int SAT_MAX = 8388607;
	localparam int SAT_MIN = -8388608;

	// configuration register indexes
	localparam logic [1:0] REG_LEARN_RATE = 2'd0;
	localparam logic [1:0] REG_TRACE_LAMBDA = 2'd1;
	localparam logic [1:0] REG_TIME_DECAY = 2'd2;
	localparam logic [1:0] REG_CAR_WIDTH = 2'd3;

	typedef struct packed {
		logic [9:0] segment_index;
		logic signed [23:0] target_accel;
		logic signed [23:0] steer_error;
		logic signed [23:0] right_clearance;
		logic signed [23:0] left_clearance;
		logic reversing;
		logic [31:0] time_ms;
	} in_word_t;

	typedef struct packed {
		logic signed [23:0] predicted_accel;
		logic table_updated;
	} out_word_t;

	// one table row: value, error and trace side by side
	typedef struct packed {
		logic signed [23:0] value;
		logic signed [23:0] error;
		logic signed [23:0] trace;
	} tbl_word_t;

	localparam int WORD_W = $bits(tbl_word_t);

	// exp(-2^(b-16)) in q30
	localparam logic [29:0] EXP_Q30 [EXP_BITS] = '{
		30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
		30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
		30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
		30'd1008687096, 30'd947573834, 30'd836230973, 30'd651257337,
		30'd395007542, 30'd145315154, 30'd19666268, 30'd360200
	};

	// divide by 2^16, round to nearest, ties away from zero
	function automatic logic signed [MW-1:0] rshr16(input logic signed [MW-1:0] v);
		logic signed [MW-1:0] mag;
		logic signed [MW-1:0] r;
		mag = (v < 0) ? -v : v;
		r = (mag + MW'(32768)) >>> 16;
		return (v < 0) ? -r : r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [MW-1:0] v);
		if (v > MW'(SAT_MAX)) begin
			return 24'(SAT_MAX);
		end
		if (v < MW'(SAT_MIN)) begin
			return 24'(SAT_MIN);
		end
		return v[23:0];
	endfunction

endpackage

// File: rtl/tdl_ram.sv
module tdl_ram #(
	parameter int WIDTH = tdl_pkg::WORD_W,
	parameter int DEPTH = tdl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tdl_div.sv
module tdl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tdl_pkg::DIV_W-1:0]       num,
	input  logic [tdl_pkg::REM_W-1:0]       den,
	output logic                            done,
	output logic [tdl_pkg::DIV_W-1:0]       quo
);
	import tdl_pkg::*;

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] den_q;
	logic [DIV_W-1:0] quo_q;
	logic [REM_W:0] trial;
	logic ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
				den_q <= den;
				quo_q <= num;
			end else if (busy_q) begin
				rem_q <= ge ? REM_W'(trial - {1'b0, den_q}) : trial[REM_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// File: rtl/td_lambda_trace_table_update.sv
// with the entry unchanged: result word read in S_OUT_RD, loaded in S_OUT once the output is free
// with a table update: up to two 20-step exp evaluations, the 56-step weight division
// and the one-entry-a-cycle sweep over the table ram come before the result word is read
// (the weight exp and division only when a clearance is short and not reversing)
// throughput: one word at a time, the input stalls until the result is loaded
// reset: tables cleared by a pass over all TABLE_ENTRIES entries, input stalled meanwhile
module td_lambda_trace_table_update #(
	parameter int TABLE_ENTRIES = tdl_pkg::TABLE_ENTRIES_DEF,
	parameter int SEGS_PER_ENTRY = tdl_pkg::SEGS_PER_ENTRY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tdl_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tdl_pkg::out_word_t  out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [22:0]         cfg_data
);
	import tdl_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = AW + 1;
	// segment to entry by reciprocal multiplication, exact for 10-bit segments
	localparam int SEG_SHIFT = 20;
	localparam int SEG_RECIP = (2 ** SEG_SHIFT + SEGS_PER_ENTRY - 1) / SEGS_PER_ENTRY;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXP, S_W_GO, S_X_MUL, S_X_DIV, S_DIV_WAIT, S_GAM,
		S_LG, S_DA, S_GE, S_AS, S_DS, S_SWEEP, S_OUT_RD, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] learn_rate_q;
	logic [16:0] trace_lambda_q;
	logic [15:0] time_decay_q;
	logic [22:0] car_width_q;

	// per-word working registers
	logic signed [23:0] target_q;
	logic signed [23:0] err_q;
	logic [16:0] w_q;
	logic [AW-1:0] q_q;
	logic [AW-1:0] le_q;
	logic [31:0] last_time_q;
	logic [31:0] dt_q;
	logic upd_q;

	// exp sequencer
	logic [30:0] acc_q;
	logic [EXP_BITS-1:0] exp_x_q;
	logic [4:0] bit_q;
	logic doing_w_q;
	logic [29:0] x_num_q;

	logic [16:0] gamma_q;
	logic signed [17:0] lg_q;
	logic signed [23:0] da_q;
	logic signed [23:0] ds_q;
	logic signed [23:0] s_q;
	logic signed [23:0] t1_q;
	logic signed [23:0] error_le_q;

	// sweep and clearing pass
	logic [CW-1:0] cnt_q;
	logic sweep_vld_s1;
	logic [AW-1:0] sweep_addr_s1;

	logic out_valid_q;
	out_word_t out_q;

	// input decode
	logic [30:0] seg_prod;
	logic [9:0] seg_div;
	logic [AW-1:0] q_in;
	logic signed [25:0] mr;
	logic signed [25:0] ml;
	logic neg_r;
	logic neg_l;
	logic signed [25:0] m_sel;
	logic [24:0] absm;
	logic signed [23:0] err_in;
	logic need_w;

	// shared multiplier
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [MW-1:0] mul_p;
	logic signed [MW-1:0] rnd;
	logic [MW-1:0] esum;
	logic [30:0] acc_next;
	logic signed [24:0] diff;

	// divider
	logic div_start;
	logic [DIV_W-1:0] div_num;
	logic [REM_W-1:0] div_den;
	logic div_done;
	logic [DIV_W-1:0] div_quo;

	// table ram
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	tbl_word_t ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	tbl_word_t ram_rdata;

	// sweep datapath
	logic signed [24:0] t25;
	logic signed [48:0] p_v;
	logic signed [48:0] p_e;
	logic signed [42:0] p_t;
	tbl_word_t sweep_word;

	logic in_acc;
	logic out_free;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	// segment to entry, clamped to the table
	assign seg_prod = 31'(in_data.segment_index) * 31'(SEG_RECIP);
	assign seg_div = seg_prod[SEG_SHIFT+9:SEG_SHIFT];
	always_comb begin
		if (32'(seg_div) > 32'(TABLE_ENTRIES - 1)) begin
			q_in = AW'(TABLE_ENTRIES - 1);
		end else begin
			q_in = AW'(seg_div);
		end
	end

	// clearance margins, left wins over right
	assign mr = 26'(in_data.right_clearance) - $signed({3'b000, car_width_q});
	assign ml = 26'(in_data.left_clearance) - $signed({3'b000, car_width_q});
	assign neg_r = mr < 0;
	assign neg_l = ml < 0;
	assign m_sel = neg_l ? ml : mr;
	assign absm = 25'(-m_sel);
	assign need_w = !in_data.reversing && (neg_l || neg_r);

	always_comb begin
		if (neg_l) begin
			err_in = sat24(-(MW'(ml) <<< 1));
		end else if (neg_r) begin
			err_in = sat24(MW'(mr) <<< 1);
		end else begin
			err_in = in_data.steer_error;
		end
	end

	// operand selection for the shared multiplier
	assign diff = 25'(target_q) - 25'(ram_rdata.value);
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_EXP: begin
				mul_a = 34'(acc_q);
				mul_b = 34'(EXP_Q30[bit_q]);
			end
			S_X_MUL: begin
				mul_a = 34'(dt_q);
				mul_b = 34'(time_decay_q);
			end
			S_X_DIV: begin
				// floor(n / 1000) by reciprocal
				mul_a = 34'(x_num_q);
				mul_b = 34'(X_RECIP);
			end
			S_LG: begin
				mul_a = 34'(trace_lambda_q);
				mul_b = 34'(gamma_q);
			end
			S_DA: begin
				mul_a = 34'(diff);
				mul_b = 34'(learn_rate_q);
			end
			S_GE: begin
				mul_a = 34'(gamma_q);
				mul_b = 34'(ram_rdata.error);
			end
			S_AS: begin
				mul_a = 34'(learn_rate_q);
				mul_b = 34'(s_q);
			end
			S_DS: begin
				mul_a = 34'(w_q);
				mul_b = 34'(t1_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign rnd = rshr16(mul_p);
	// q30 product rounded back to q30
	assign esum = mul_p + MW'(2 ** 29);
	assign acc_next = esum[60:30];

	// divider feed: weight 2e/(1+e)
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		if (state_q == S_W_GO) begin
			div_start = 1'b1;
			div_num = (DIV_W'(acc_q) << 17)
				+ ((DIV_W'(1) << 30) + DIV_W'(acc_q) >> 1);
			div_den = REM_W'((32'd1 << 30) + 32'(acc_q));
		end
	end

	tdl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sweep: the old entry counts as trace 1.0
	assign t25 = (sweep_addr_s1 == le_q) ? 25'sd65536 : 25'(ram_rdata.trace);
	assign p_v = t25 * da_q;
	assign p_e = t25 * ds_q;
	assign p_t = t25 * lg_q;
	assign sweep_word.value = sat24(MW'(ram_rdata.value) + rshr16(MW'(p_v)));
	assign sweep_word.error = sat24(MW'(ram_rdata.error) + rshr16(MW'(p_e)));
	assign sweep_word.trace = sat24(rshr16(MW'(p_t)));

	// table ram ports
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sweep_addr_s1;
		ram_wdata = sweep_word;
		ram_re = 1'b0;
		ram_raddr = q_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = '0;
			end
			S_LG: begin
				ram_re = 1'b1;
				ram_raddr = le_q;
			end
			S_DA: begin
				ram_re = 1'b1;
				ram_raddr = q_q;
			end
			S_SWEEP: begin
				ram_we = sweep_vld_s1;
				ram_re = cnt_q != CW'(TABLE_ENTRIES);
				ram_raddr = cnt_q[AW-1:0];
			end
			S_OUT_RD: begin
				ram_re = 1'b1;
				ram_raddr = q_q;
			end
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	tdl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			sweep_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			le_q <= AW'(TABLE_ENTRIES - 1);
			last_time_q <= '0;
			learn_rate_q <= 16'd3277;
			trace_lambda_q <= 17'd65536;
			time_decay_q <= 16'd256;
			car_width_q <= 23'd131072;
			doing_w_q <= 1'b0;
			upd_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LEARN_RATE: learn_rate_q <= cfg_data[15:0];
					REG_TRACE_LAMBDA: trace_lambda_q <= cfg_data[16:0];
					REG_TIME_DECAY: time_decay_q <= cfg_data[15:0];
					REG_CAR_WIDTH: car_width_q <= cfg_data;
				endcase
			end

			// result word taken downstream, unless a new one is loaded
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						q_q <= q_in;
						target_q <= in_data.reversing ? -24'sd65536 : in_data.target_accel;
						err_q <= err_in;
						dt_q <= in_data.time_ms - last_time_q;
						if (q_in == le_q) begin
							upd_q <= 1'b0;
							state_q <= S_OUT_RD;
						end else begin
							upd_q <= 1'b1;
							last_time_q <= in_data.time_ms;
							w_q <= in_data.reversing ? 17'd0 : 17'd65536;
							doing_w_q <= 1'b1;
							if (need_w) begin
								bit_q <= '0;
								exp_x_q <= absm[EXP_BITS-1:0];
								if (absm[24:EXP_BITS] != '0) begin
									// exp underflows to zero
									acc_q <= '0;
									state_q <= S_W_GO;
								end else begin
									acc_q <= 31'd1 << 30;
									state_q <= S_EXP;
								end
							end else begin
								state_q <= S_X_MUL;
							end
						end
					end
				end
				S_EXP: begin
					if (exp_x_q[bit_q]) begin
						acc_q <= acc_next;
					end
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'(EXP_BITS - 1)) begin
						state_q <= doing_w_q ? S_W_GO : S_GAM;
					end
				end
				S_W_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_X_MUL: begin
					doing_w_q <= 1'b0;
					if (mul_p >= MW'(X_LIMIT)) begin
						// decay argument of 16.0 or more, exp underflows
						acc_q <= '0;
						state_q <= S_GAM;
					end else begin
						x_num_q <= {mul_p[21:0], 8'd0};
						state_q <= S_X_DIV;
					end
				end
				S_X_DIV: begin
					exp_x_q <= mul_p[X_SHIFT+EXP_BITS-1:X_SHIFT];
					acc_q <= 31'd1 << 30;
					bit_q <= '0;
					state_q <= S_EXP;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						w_q <= div_quo[16:0];
						state_q <= S_X_MUL;
					end
				end
				S_GAM: begin
					// q30 to q16 with rounding
					gamma_q <= 17'((32'(acc_q) + 32'd8192) >> 14);
					state_q <= S_LG;
				end
				S_LG: begin
					lg_q <= rnd[17:0];
					state_q <= S_DA;
				end
				S_DA: begin
					da_q <= sat24(rnd);
					error_le_q <= ram_rdata.error;
					state_q <= S_GE;
				end
				S_GE: begin
					s_q <= sat24(MW'(err_q) + rnd - MW'(error_le_q));
					state_q <= S_AS;
				end
				S_AS: begin
					t1_q <= rnd[23:0];
					state_q <= S_DS;
				end
				S_DS: begin
					ds_q <= sat24(rnd);
					cnt_q <= '0;
					sweep_vld_s1 <= 1'b0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (cnt_q != CW'(TABLE_ENTRIES)) begin
						sweep_vld_s1 <= 1'b1;
						sweep_addr_s1 <= cnt_q[AW-1:0];
						cnt_q <= cnt_q + CW'(1);
					end else begin
						sweep_vld_s1 <= 1'b0;
						if (!sweep_vld_s1) begin
							state_q <= S_OUT_RD;
						end
					end
				end
				S_OUT_RD: begin
					le_q <= q_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_q.predicted_accel <= ram_rdata.value;
						out_q.table_updated <= upd_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tdl_pkg::*;

	localparam int ENTRIES = 1024;
	localparam int N_DIRECTED = 16;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 2500;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [22:0] cfg_data;

	td_lambda_trace_table_update uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block's learning state
	longint value_mem [ENTRIES];
	longint error_mem [ENTRIES];
	longint trace_mem [ENTRIES];
	int unsigned prev_entry;
	longint unsigned prev_stamp;
	longint unsigned alpha_q16;
	longint unsigned lambda_q16;
	longint unsigned beta_q8;
	longint carw_q16;

	// exp(-2^(b-16)) in q30
	longint unsigned exp_step [20] = '{
		1073725440, 1073709056, 1073676290, 1073610760, 1073479712,
		1073217664, 1072693760, 1071646719, 1069555701, 1065385899,
		1057095000, 1040706261, 1008687096, 947573834, 836230973,
		651257337, 395007542, 145315154, 19666268, 360200
	};

	out_word_t pending_words [$];
	int err_count;
	longint cycle_count;
	bit quiet;
	bit hold_go;
	bit hold_on;

	typedef struct {
		in_word_t w;
		bit fixed;
		out_word_t o;
	} dir_row_t;

	dir_row_t dir_rows [N_DIRECTED];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat_q824(longint v);
		if (v > SAT_MAX) return SAT_MAX;
		if (v < SAT_MIN) return SAT_MIN;
		return v;
	endfunction

	// divide by 2^sh, nearest, ties away from zero
	function automatic longint round_shift(longint v, int sh);
		longint half;
		half = longint'(1) <<< (sh - 1);
		if (v >= 0) return (v + half) >>> sh;
		return -(((-v) + half) >>> sh);
	endfunction

	// exp(-x), x in q16, result in q30
	function automatic longint unsigned decay_q30(longint unsigned x);
		longint unsigned acc;
		acc = 64'd1 << 30;
		if (x >= (64'd1 << 20)) return 0;
		for (int b = 0; b < 20; b++)
			if (x[b]) acc = (acc * exp_step[b] + (64'd1 << 29)) >> 30;
		return acc;
	endfunction

	// 1-|tanh(m/2)| for a negative margin
	function automatic longint edge_weight(longint m);
		longint unsigned e;
		longint unsigned den;
		e = decay_q30(longint'(-m));
		den = (64'd1 << 30) + e;
		return longint'((2 * e * 65536 + den / 2) / den);
	endfunction

	function automatic out_word_t predict_tick(in_word_t w);
		longint target, err, mr, ml, wt, gam, lg, da, s, ds, t;
		longint unsigned dt, x;
		int unsigned q, le;
		bit upd;
		out_word_t o;
		target = longint'($signed(w.target_accel));
		err = longint'($signed(w.steer_error));
		mr = longint'($signed(w.right_clearance)) - carw_q16;
		ml = longint'($signed(w.left_clearance)) - carw_q16;
		wt = 65536;
		upd = 1'b0;
		if (mr < 0) begin
			wt = edge_weight(mr);
			err = sat_q824(2 * mr);
		end
		// left overrides right
		if (ml < 0) begin
			wt = edge_weight(ml);
			err = sat_q824(-2 * ml);
		end
		if (w.reversing) begin
			wt = 0;
			target = -65536;
		end
		q = w.segment_index;
		if (q > ENTRIES - 1) q = ENTRIES - 1;
		if (q != prev_entry) begin
			le = prev_entry;
			dt = (longint'(w.time_ms) - prev_stamp) & 64'hFFFF_FFFF;
			x = (dt * beta_q8 * 256) / 1000;
			gam = longint'((decay_q30(x) + (64'd1 << 13)) >> 14);
			lg = round_shift(longint'(lambda_q16) * gam, 16);
			prev_stamp = w.time_ms;
			trace_mem[le] = 65536;
			da = sat_q824(round_shift(longint'(alpha_q16) * (target - value_mem[le]), 16));
			s = sat_q824(err + round_shift(gam * error_mem[q], 16) - error_mem[le]);
			ds = sat_q824(round_shift(wt * round_shift(longint'(alpha_q16) * s, 16), 16));
			for (int i = 0; i < ENTRIES; i++) begin
				t = trace_mem[i];
				value_mem[i] = sat_q824(value_mem[i] + round_shift(t * da, 16));
				error_mem[i] = sat_q824(error_mem[i] + round_shift(t * ds, 16));
				trace_mem[i] = sat_q824(round_shift(t * lg, 16));
			end
			prev_entry = q;
			upd = 1'b1;
		end
		o.predicted_accel = value_mem[q][23:0];
		o.table_updated = upd;
		return o;
	endfunction

	function automatic in_word_t mk_word(int seg, longint tgt, longint serr, longint rc,
		longint lc, bit rev, longint unsigned tms);
		in_word_t w;
		w.segment_index = seg[9:0];
		w.target_accel = tgt[23:0];
		w.steer_error = serr[23:0];
		w.right_clearance = rc[23:0];
		w.left_clearance = lc[23:0];
		w.reversing = rev;
		w.time_ms = tms[31:0];
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		err_count++;
	endtask

	// present one word and wait for it to be taken
	task automatic send_word(in_word_t w, bit fixed, out_word_t fixed_o);
		out_word_t o;
		if (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		// taken at this edge
		o = predict_tick(w);
		pending_words.push_back(fixed ? fixed_o : o);
	endtask

	task automatic write_reg(logic [1:0] idx, longint unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[22:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LEARN_RATE: alpha_q16 = val & 64'hFFFF;
			REG_TRACE_LAMBDA: lambda_q16 = val & 64'h1FFFF;
			REG_TIME_DECAY: beta_q8 = val & 64'hFFFF;
			default: carw_q16 = longint'(val & 64'h7FFFFF);
		endcase
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// random tick, mostly plausible driving with some wild values
	task automatic send_random(ref int last_seg, ref longint unsigned stamp);
		int seg;
		longint rc, lc, tgt, serr;
		bit rev;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) seg = last_seg;
		else if (pick < 45) seg = ENTRIES - 1;
		else if (pick < 50) seg = 0;
		else seg = $urandom_range(ENTRIES - 1);
		if ($urandom_range(1)) begin
			rc = $signed(24'($urandom));
			lc = $signed(24'($urandom));
		end else begin
			rc = sat_q824(carw_q16 + longint'($urandom_range(600000)) - 300000);
			lc = sat_q824(carw_q16 + longint'($urandom_range(600000)) - 300000);
		end
		tgt = $urandom_range(3) == 0 ? longint'($signed(24'($urandom)))
			: longint'($urandom_range(200000)) - 100000;
		serr = $signed(24'($urandom));
		rev = $urandom_range(9) == 0;
		pick = $urandom_range(9);
		if (pick < 8) stamp = (stamp + $urandom_range(2000)) & 64'hFFFF_FFFF;
		else if (pick < 9) stamp = $urandom;
		else stamp = (stamp + $urandom_range(32'h7FFF_FFFF)) & 64'hFFFF_FFFF;
		send_word(mk_word(seg, tgt, serr, rc, lc, rev, stamp), 1'b0, '0);
		last_seg = seg;
	endtask

	// result side: stall at random, or hold off on request
	always @(posedge clk) begin
		if (hold_on) out_stall <= 1'b1;
		else if (quiet) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < 8);
	end

	// long hold-off while the sender keeps offering
	initial begin
		hold_on = 1'b0;
		@(posedge hold_go);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	end

	// checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("word with nothing pending", out_data.predicted_accel, 0);
			end else begin
				if (out_data.predicted_accel !== pending_words[0].predicted_accel)
					report_mismatch("predicted_accel",
						$signed(out_data.predicted_accel),
						$signed(pending_words[0].predicted_accel));
				if (out_data.table_updated !== pending_words[0].table_updated)
					report_mismatch("table_updated", out_data.table_updated,
						pending_words[0].table_updated);
				void'(pending_words.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		longint unsigned cfg_sets [5][4];
		int last_seg;
		longint unsigned stamp;
		// all inputs known from the start
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEARN_RATE;
		cfg_data = '0;
		quiet = 1'b0;
		hold_go = 1'b0;
		err_count = 0;
		cycle_count = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			value_mem[i] = 0;
			error_mem[i] = 0;
			trace_mem[i] = 0;
		end
		prev_entry = ENTRIES - 1;
		prev_stamp = 0;
		alpha_q16 = 3277;
		lambda_q16 = 65536;
		beta_q8 = 256;
		carw_q16 = 131072;

		// directed table; fixed results only where obvious
		dir_rows[0] = '{mk_word(0, 0, 0, 196608, 196608, 0, 0), 1, '{24'sd0, 1'b1}};
		dir_rows[1] = '{mk_word(0, 5000, 7, 196608, 196608, 0, 10), 1, '{24'sd0, 1'b0}};
		dir_rows[2] = '{mk_word(1023, SAT_MAX, 0, 196608, 196608, 0, 100), 0, '0};
		dir_rows[3] = '{mk_word(0, SAT_MIN, 0, 196608, 196608, 0, 200), 0, '0};
		dir_rows[4] = '{mk_word(1, 30000, 1000, 196608, 196608, 1, 300), 0, '0};
		dir_rows[5] = '{mk_word(2, 20000, 0, SAT_MIN, 196608, 0, 400), 0, '0};
		dir_rows[6] = '{mk_word(3, 20000, 0, 196608, 65536, 0, 500), 0, '0};
		dir_rows[7] = '{mk_word(4, -20000, 0, 100000, 30000, 0, 600), 0, '0};
		dir_rows[8] = '{mk_word(5, 10000, 500, SAT_MAX, SAT_MAX, 0, 700), 0, '0};
		// huge elapsed time, then wrap of the time stamp
		dir_rows[9] = '{mk_word(6, 10000, 0, 196608, 196608, 0, 64'hFFFF_FFF0), 0, '0};
		dir_rows[10] = '{mk_word(7, 10000, 0, 196608, 196608, 0, 16), 0, '0};
		dir_rows[11] = '{mk_word(7, 10000, SAT_MAX, 196608, 196608, 0, 17), 0, '0};
		dir_rows[12] = '{mk_word(8, -1, SAT_MIN, 196608, 196608, 0, 18), 0, '0};
		// margin exactly zero and just below
		dir_rows[13] = '{mk_word(9, 1, 0, 131072, 131072, 0, 40), 0, '0};
		dir_rows[14] = '{mk_word(10, 1, 0, 131071, 131072, 0, 60), 0, '0};
		dir_rows[15] = '{mk_word(512, 12345, -12345, 196608, 196608, 0, 60), 0, '0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].o);
		last_seg = 512;
		stamp = 60;

		cfg_sets[0] = '{65535, 65536, 65535, 0};
		cfg_sets[1] = '{0, 0, 0, 8388607};
		cfg_sets[2] = '{3277, 131071, 1, 131072};
		cfg_sets[3] = '{40000, 30000, 256, 200000};
		cfg_sets[4] = '{3277, 65536, 256, 131072};

		for (int p = 0; p < 5; p++) begin
			drain();
			for (int r = 0; r < 4; r++)
				write_reg(r[1:0], cfg_sets[p][r]);
			quiet = (p == 2);
			if (p == 3) hold_go = 1'b1;
			for (int n = 0; n < 105; n++)
				send_random(last_seg, stamp);
			quiet = 1'b0;
		end

		drain();
		repeat (100) @(posedge clk);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/tdl_pkg.sv
rtl/tdl_ram.sv
rtl/tdl_div.sv
rtl/td_lambda_trace_table_update.sv
tb/testbench.sv
